// ----- sv/bbs_pkg.sv -----
// Shared constants, register codes and types of the baseband bit synchroniser.
package bbs_pkg;

  localparam int unsigned WINDOW_LEN  = 50;
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned LEVEL_BITS  = 12;
  localparam int unsigned PHASE_BITS  = 8;
  localparam int unsigned CFG_BITS    = 12;
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_LEN + 1);

  // Floor division of the window sum by WINDOW_LEN as a reciprocal multiply.
  localparam int unsigned DIV_SHIFT  = SUM_BITS + $clog2(WINDOW_LEN) + 1;
  localparam longint unsigned WIN_RECIP =
      ((64'd1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int unsigned RECIP_BITS = $clog2(WIN_RECIP + 1);
  localparam int unsigned PROD_BITS  = SUM_BITS + RECIP_BITS;
  localparam int unsigned FULL_BITS  = PROD_BITS - DIV_SHIFT;

  // Level times four, floor-divided by five.
  localparam int unsigned DAC_SHIFT  = LEVEL_BITS + 4;
  localparam int unsigned DAC_RECIP  = ((1 << DAC_SHIFT) + 4) / 5;
  localparam int unsigned DAC_PBITS  = LEVEL_BITS + 2 + $clog2(DAC_RECIP + 1);

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  localparam logic [11:0]          THRESH_HIGH_RST = 12'd2000;
  localparam logic [11:0]          THRESH_LOW_RST  = 12'd1950;
  localparam logic [PHASE_BITS-1:0] PERIOD_RST     = 8'd50;
  localparam logic [PHASE_BITS-1:0] SAMPLE_PH_RST  = 8'd40;

  typedef enum logic [1:0] {
    REG_THRESH_HIGH   = 2'd0,
    REG_THRESH_LOW    = 2'd1,
    REG_SYMBOL_PERIOD = 2'd2,
    REG_SAMPLE_PHASE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] thresh_high;
    logic [LEVEL_BITS-1:0] thresh_low;
    logic [PHASE_BITS-1:0] symbol_period;
    logic [PHASE_BITS-1:0] sample_phase;
  } cfg_t;

  typedef struct packed {
    logic slicer_bit;
    logic bit_clock;
    logic decision_strobe;
    logic decoded_bit;
  } sync_flags_t;

endpackage

// ----- sv/baseband_bit_sync_receiver.sv -----
// Top level: moving-average slicer with early-late bit synchronisation.
// Throughput is one sample per cycle; the four-stage pipeline stalls only from the output side.
// The window is a row of WINDOW_LEN delay cells that shift once per accepted sample.
// Reset clears the delay cells, running sum, timing state and pipeline valids at once,
// and loads the configuration registers with their default values.
module baseband_bit_sync_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // [11:0] adc_sample
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [11:0] filtered_level, [23:12] dac_code, [24] slicer_bit, [25] bit_clock,
  // [26] decision_strobe, [27] decoded_bit
  output logic [31:0]                    m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [bbs_pkg::CFG_BITS-1:0]   cfg_data_i
);
  import bbs_pkg::*;

  cfg_t cfg_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  logic acc;

  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] taps [WINDOW_LEN+1];
  logic [SUM_BITS-1:0]    sum_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic [FULL_BITS-1:0]   level_full;
  logic [LEVEL_BITS-1:0]  level;
  logic [LEVEL_BITS-1:0]  level_q;
  logic [DAC_PBITS-1:0]   dac_prod_q;
  sync_flags_t            flags;

  logic [LEVEL_BITS-1:0]  out_level_q;
  logic [LEVEL_BITS-1:0]  out_dac_q;
  sync_flags_t            out_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thresh_high   <= THRESH_HIGH_RST;
      cfg_q.thresh_low    <= THRESH_LOW_RST;
      cfg_q.symbol_period <= PERIOD_RST;
      cfg_q.sample_phase  <= SAMPLE_PH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_THRESH_HIGH:   cfg_q.thresh_high   <= cfg_data_i[LEVEL_BITS-1:0];
        REG_THRESH_LOW:    cfg_q.thresh_low    <= cfg_data_i[LEVEL_BITS-1:0];
        REG_SYMBOL_PERIOD: cfg_q.symbol_period <= cfg_data_i[PHASE_BITS-1:0];
        REG_SAMPLE_PHASE:  cfg_q.sample_phase  <= cfg_data_i[PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;
  assign acc = s_axis_tvalid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= acc;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  assign sample  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign taps[0] = sample;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cells
    bbs_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (acc),
      .sample_i (taps[i]),
      .sample_o (taps[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (acc) begin
      sum_q <= sum_q + SUM_BITS'(sample) - SUM_BITS'(taps[WINDOW_LEN]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      prod_q <= PROD_BITS'(sum_q) * PROD_BITS'(WIN_RECIP);
    end
  end

  assign level_full = prod_q[PROD_BITS-1:DIV_SHIFT];
  assign level = (level_full > FULL_BITS'(LEVEL_MAX)) ? LEVEL_MAX
                                                      : level_full[LEVEL_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      level_q    <= level;
      dac_prod_q <= DAC_PBITS'({level, 2'b00}) * DAC_PBITS'(DAC_RECIP);
    end
  end

  bbs_sync u_sync (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (en3 && v2_q),
    .level_i (level),
    .cfg_i   (cfg_q),
    .flags_o (flags)
  );

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      out_level_q <= level_q;
      out_dac_q   <= dac_prod_q[DAC_SHIFT +: LEVEL_BITS];
      out_flags_q <= flags;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {4'b0000, out_flags_q.decoded_bit, out_flags_q.decision_strobe,
                          out_flags_q.bit_clock, out_flags_q.slicer_bit, out_dac_q,
                          out_level_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_BITS'(WINDOW_LEN * ((1 << SAMPLE_BITS) - 1)))
    else $error("window sum exceeds full-scale window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && v4_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline is full and stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_dac_q <= out_level_q)
    else $error("DAC code above filtered level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> v1_q)
    else $error("accepted sample lost from first stage");

endmodule

// ----- sv/bbs_cell.sv -----
// One tap of the sample delay line that forms the moving-average window.
module bbs_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              shift_i,
  input  logic [bbs_pkg::SAMPLE_BITS-1:0]   sample_i,
  output logic [bbs_pkg::SAMPLE_BITS-1:0]   sample_o
);
  import bbs_pkg::*;

  logic [SAMPLE_BITS-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

// ----- sv/bbs_sync.sv -----
// Hysteresis slicer, early-late symbol timing and differential decoder.
module bbs_sync (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             upd_i,
  input  logic [bbs_pkg::LEVEL_BITS-1:0]   level_i,
  input  bbs_pkg::cfg_t                    cfg_i,
  output bbs_pkg::sync_flags_t             flags_o
);
  import bbs_pkg::*;

  logic                  slicer_q, slicer_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic                  clk_q, clk_d;
  logic                  last_q, last_d;
  logic                  dec_q, dec_d;
  logic                  strobe_q, strobe_d;
  logic [PHASE_BITS-1:0] half;
  logic [PHASE_BITS:0]   ph_inc;
  logic [PHASE_BITS:0]   ph_adj;

  always_comb begin
    slicer_d = slicer_q;
    if (level_i >= cfg_i.thresh_high) begin
      slicer_d = 1'b1;
    end
    if (level_i <= cfg_i.thresh_low) begin
      slicer_d = 1'b0;
    end

    half   = cfg_i.symbol_period >> 1;
    ph_inc = {1'b0, phase_q} + 1'b1;
    ph_adj = ph_inc;
    if (slicer_d != slicer_q) begin
      if (ph_inc > {1'b0, half}) begin
        ph_adj = ph_inc - 1'b1;
      end else if (ph_inc < {1'b0, half}) begin
        ph_adj = ph_inc + 1'b1;
      end
    end

    clk_d   = clk_q;
    phase_d = ph_adj[PHASE_BITS-1:0];
    if (ph_adj >= {1'b0, cfg_i.symbol_period}) begin
      clk_d   = 1'b0;
      phase_d = '0;
    end else if (ph_adj == {1'b0, half}) begin
      clk_d = 1'b1;
    end

    strobe_d = (phase_d == cfg_i.sample_phase);
    last_d   = last_q;
    dec_d    = dec_q;
    if (strobe_d) begin
      dec_d  = last_q ^ slicer_d;
      last_d = slicer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slicer_q <= 1'b0;
      phase_q  <= '0;
      clk_q    <= 1'b0;
      last_q   <= 1'b0;
      dec_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else if (upd_i) begin
      slicer_q <= slicer_d;
      phase_q  <= phase_d;
      clk_q    <= clk_d;
      last_q   <= last_d;
      dec_q    <= dec_d;
      strobe_q <= strobe_d;
    end
  end

  assign flags_o.slicer_bit      = slicer_q;
  assign flags_o.bit_clock       = clk_q;
  assign flags_o.decision_strobe = strobe_q;
  assign flags_o.decoded_bit     = dec_q;

  // A strobe always leaves the latched decision equal to the slicer level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && strobe_d |=> last_q == slicer_q)
    else $error("decision latch does not follow slicer on strobe");

endmodule
